@@ hdl/gda_pkg.sv @@
// Package for the Gregorian date arithmetic block: widths, codes, calendar tables,
// controller/datapath command and status types. No dependencies.
package gda_pkg;

   localparam int MAX_YEAR   = 9999;
   localparam int YEAR_BIAS  = 400;

   localparam int OP_W       = 3;
   localparam int DAY_W      = 5;
   localparam int MON_W      = 4;
   localparam int YEAR_W     = 14;
   localparam int AMT_W      = 16;
   localparam int DIST_W     = 22;
   localparam int CMP_W      = 2;
   localparam int YB_W       = 15;   // biased year
   localparam int DN_W       = 24;   // day number
   localparam int T_W        = 19;   // signed month count
   localparam int RY_W       = 18;   // signed result year
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   // ceil-reciprocal constants: q = (x * RECIP) >> SHIFT
   localparam int RECIP_100  = 20972;
   localparam int SHIFT_100  = 21;
   localparam int RECIP_400  = 20972;
   localparam int SHIFT_400  = 23;
   localparam int RECIP_12   = 349526;
   localparam int SHIFT_12   = 22;

   // day number of 1 Jan of year 0 (biased year YEAR_BIAS)
   localparam int DBY_BIAS   = 365 * YEAR_BIAS + YEAR_BIAS / 4 - YEAR_BIAS / 100
                               + YEAR_BIAS / 400;

   localparam logic [CMP_W-1:0] CMP_EARLIER = 2'd0;
   localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'd1;
   localparam logic [CMP_W-1:0] CMP_LATER   = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_DAYS   = 3'd0,
      OP_SUB_DAYS   = 3'd1,
      OP_ADD_MONTHS = 3'd2,
      OP_SUB_MONTHS = 3'd3,
      OP_ADD_YEARS  = 3'd4,
      OP_SUB_YEARS  = 3'd5,
      OP_DIST       = 3'd6,
      OP_RSVD       = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      SRC_NONE  = 3'd0,
      SRC_ERR   = 3'd1,
      SRC_DIST  = 3'd2,
      SRC_A     = 3'd3,
      SRC_YEAR  = 3'd4,
      SRC_MONTH = 3'd5,
      SRC_DAY   = 3'd6
   } src_type;

   typedef enum logic [2:0] {
      YSEL_HOLD = 3'd0,
      YSEL_YY_A = 3'd1,
      YSEL_YY_B = 3'd2,
      YSEL_INC  = 3'd3,
      YSEL_DEC  = 3'd4
   } ysel_type;

   typedef struct packed {
      logic     load;
      ysel_type ysel;
      logic     set_valid;
      logic     n_load;
      logic     dist_load;
      logic     t_load;
      logic     rem_load;
      logic     walk_step;
      logic     fin;
      src_type  src;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   amt_neg;
      logic   amt_zero;
      logic   n_below;
      logic   dby_gt;
      logic   walk_more;
      logic   out_free;
   } sts_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] k,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (k) inside
         4'd1:                   len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] cum_days(input logic [MON_W-1:0] mm);
      logic [8:0] c;
      case (mm)
         4'd0:    c = 9'd0;
         4'd1:    c = 9'd31;
         4'd2:    c = 9'd59;
         4'd3:    c = 9'd90;
         4'd4:    c = 9'd120;
         4'd5:    c = 9'd151;
         4'd6:    c = 9'd181;
         4'd7:    c = 9'd212;
         4'd8:    c = 9'd243;
         4'd9:    c = 9'd273;
         4'd10:   c = 9'd304;
         4'd11:   c = 9'd334;
         default: c = 9'd0;
      endcase
      return c;
   endfunction

   // month index 0..11 with linear wrap of month 0 and 13..15
   function automatic logic [MON_W-1:0] mm_of(input logic [MON_W-1:0] m);
      logic [MON_W-1:0] mm;
      if (m == 4'd0) begin
         mm = 4'd11;
      end else if (m <= 4'd12) begin
         mm = m - 4'd1;
      end else begin
         mm = m - 4'd13;
      end
      return mm;
   endfunction

   function automatic logic [YB_W-1:0] yy_of(input logic [MON_W-1:0] m,
                                            input logic [YEAR_W-1:0] y);
      logic [YB_W-1:0] base;
      logic [YB_W-1:0] yy;
      base = YB_W'(y) + YB_W'(YEAR_BIAS);
      if (m == 4'd0) begin
         yy = base - 15'd1;
      end else if (m >= 4'd13) begin
         yy = base + 15'd1;
      end else begin
         yy = base;
      end
      return yy;
   endfunction

endpackage

@@ hdl/gda_dp.sv @@
// Datapath of the date arithmetic block: operand registers, day-count unit with
// registered reciprocal quotients, year search and month walk registers, output stage.
// Depends on gda_pkg; driven by gda_ctrl through cmd/sts.
module gda_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gda_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [gda_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gda_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  gda_pkg::cmd_type                  cmd,
   output gda_pkg::sts_type                  sts
);
   import gda_pkg::*;

   // operand registers
   op_type              op_ff;
   logic [DAY_W-1:0]    da_ff, db_ff;
   logic [MON_W-1:0]    ma_ff, mb_ff;
   logic [YEAR_W-1:0]   ya_ff, yb_ff;
   logic [AMT_W-1:0]    amt_ff;

   // work registers
   logic [YB_W-1:0]     y_ff, y_in;
   logic [8:0]          q100_ff;
   logic [6:0]          q400_ff;
   logic [DN_W-1:0]     n_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [T_W-1:0]      t_ff;
   logic [14:0]         q12_ff;
   logic [8:0]          r_ff;
   logic [MON_W-1:0]    k_ff;
   logic                leap_ff;
   logic                valid_ff;

   // output stage
   logic                rsp_tvalid_ff;
   logic [DAY_W-1:0]    res_day_ff;
   logic [MON_W-1:0]    res_month_ff;
   logic [YEAR_W-1:0]   res_year_ff;
   logic                first_valid_ff;
   logic [CMP_W-1:0]    compare_ff;
   logic [DIST_W-1:0]   distance_ff;
   logic                error_ff;

   logic [29:0]         p100, p400;
   logic [36:0]         p12;
   logic [DN_W-1:0]     dby, dn_a, dn_b, amt_ext, n_in, diff;
   logic [MON_W-1:0]    mm_a, mm_b, rem12;
   logic                leap, valid_in;
   logic [CMP_W-1:0]    cmp;
   logic [T_W-1:0]      t_base, t_in;
   logic [DAY_W-1:0]    rd_fin;
   logic [MON_W-1:0]    rm_fin;
   logic [RY_W-1:0]     ry_fin;
   logic                dated, below, err_fin, over;
   logic [DIST_W-1:0]   dist_fin;

   // day-count unit
   assign p100 = 30'(y_ff + 15'd99)  * 30'(RECIP_100);
   assign p400 = 30'(y_ff + 15'd399) * 30'(RECIP_400);
   assign p12  = 37'(t_ff[T_W-2:0])  * 37'(RECIP_12);

   assign dby  = DN_W'(y_ff) * DN_W'(365) + DN_W'((y_ff + 15'd3) >> 2)
                 - DN_W'(q100_ff) + DN_W'(q400_ff);
   assign leap = ((16'(q100_ff) * 16'd100) == 16'(y_ff))
                 ? ((16'(q400_ff) * 16'd400) == 16'(y_ff))
                 : (y_ff[1:0] == 2'b00);

   assign mm_a = mm_of(ma_ff);
   assign mm_b = mm_of(mb_ff);
   assign dn_a = dby + DN_W'(cum_days(mm_a)) + DN_W'(da_ff) - DN_W'(1)
                 + DN_W'(leap && (mm_a >= 4'd2));
   assign dn_b = dby + DN_W'(cum_days(mm_b)) + DN_W'(db_ff) - DN_W'(1)
                 + DN_W'(leap && (mm_b >= 4'd2));

   assign amt_ext = DN_W'(amt_ff[AMT_W-2:0]);

   always_comb begin
      case (op_ff)
         OP_ADD_DAYS: n_in = dn_a + amt_ext;
         OP_SUB_DAYS: n_in = dn_a - amt_ext;
         default:     n_in = dn_a;
      endcase
   end

   assign diff = (n_ff >= dn_b) ? (n_ff - dn_b) : (dn_b - n_ff);

   assign t_base = T_W'(ya_ff) * T_W'(12) + T_W'(ma_ff) - T_W'(1);
   assign t_in   = (op_ff == OP_ADD_MONTHS) ? (t_base + T_W'(amt_ff[AMT_W-2:0]))
                                            : (t_base - T_W'(amt_ff[AMT_W-2:0]));
   assign rem12  = 4'(18'(t_ff[T_W-2:0]) - 18'(q12_ff) * 18'd12);

   assign valid_in = (ma_ff >= 4'd1) && (ma_ff <= 4'd12) && (da_ff != 5'd0)
                     && (da_ff <= month_len(ma_ff - 4'd1, leap));

   always_comb begin
      if (ya_ff != yb_ff) begin
         cmp = (ya_ff < yb_ff) ? CMP_EARLIER : CMP_LATER;
      end else if (ma_ff != mb_ff) begin
         cmp = (ma_ff < mb_ff) ? CMP_EARLIER : CMP_LATER;
      end else if (da_ff != db_ff) begin
         cmp = (da_ff < db_ff) ? CMP_EARLIER : CMP_LATER;
      end else begin
         cmp = CMP_EQUAL;
      end
   end

   always_comb begin
      case (cmd.ysel)
         YSEL_YY_A: y_in = yy_of(ma_ff, ya_ff);
         YSEL_YY_B: y_in = yy_of(mb_ff, yb_ff);
         YSEL_INC:  y_in = y_ff + 15'd1;
         YSEL_DEC:  y_in = y_ff - 15'd1;
         default:   y_in = y_ff;
      endcase
      if (cmd.load) begin
         y_in = YB_W'(req_tdata[22:9]) + YB_W'(YEAR_BIAS);
      end
   end

   // result selection
   always_comb begin
      rd_fin   = '0;
      rm_fin   = '0;
      ry_fin   = '0;
      dated    = 1'b0;
      below    = 1'b0;
      err_fin  = 1'b0;
      dist_fin = '0;
      case (cmd.src)
         SRC_ERR:  err_fin = 1'b1;
         SRC_DIST: dist_fin = dist_ff;
         SRC_A: begin
            dated  = 1'b1;
            rd_fin = da_ff;
            rm_fin = ma_ff;
            ry_fin = RY_W'(ya_ff);
         end
         SRC_YEAR: begin
            dated  = 1'b1;
            rd_fin = da_ff;
            rm_fin = ma_ff;
            ry_fin = (op_ff == OP_ADD_YEARS)
                     ? (RY_W'(ya_ff) + RY_W'(amt_ff[AMT_W-2:0]))
                     : (RY_W'(ya_ff) - RY_W'(amt_ff[AMT_W-2:0]));
            below  = ry_fin[RY_W-1];
         end
         SRC_MONTH: begin
            dated  = 1'b1;
            rd_fin = da_ff;
            rm_fin = rem12 + 4'd1;
            ry_fin = RY_W'(q12_ff);
            below  = t_ff[T_W-1];
         end
         SRC_DAY: begin
            dated  = 1'b1;
            rd_fin = r_ff[DAY_W-1:0] + 5'd1;
            rm_fin = k_ff + 4'd1;
            ry_fin = RY_W'(y_ff) - RY_W'(YEAR_BIAS);
         end
         default: ;
      endcase
      over = !ry_fin[RY_W-1] && (ry_fin[RY_W-2:0] > (RY_W-1)'(MAX_YEAR));
      if (dated) begin
         if (below) begin
            rd_fin  = '0;
            rm_fin  = '0;
            ry_fin  = '0;
            err_fin = 1'b1;
         end else if (over) begin
            rd_fin  = 5'd31;
            rm_fin  = 4'd12;
            ry_fin  = RY_W'(MAX_YEAR);
            err_fin = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_tuser);
         da_ff  <= req_tdata[4:0];
         ma_ff  <= req_tdata[8:5];
         ya_ff  <= req_tdata[22:9];
         amt_ff <= req_tdata[38:23];
         db_ff  <= req_tdata[43:39];
         mb_ff  <= req_tdata[47:44];
         yb_ff  <= req_tdata[61:48];
      end
      y_ff    <= y_in;
      q100_ff <= p100[29:SHIFT_100];
      q400_ff <= p400[29:SHIFT_400];
      q12_ff  <= p12[36:SHIFT_12];
      if (cmd.set_valid) begin
         valid_ff <= valid_in;
      end
      if (cmd.n_load) begin
         n_ff <= n_in;
      end
      if (cmd.dist_load) begin
         dist_ff <= (diff[DN_W-1:DIST_W] != '0) ? '1 : diff[DIST_W-1:0];
      end
      if (cmd.t_load) begin
         t_ff <= t_in;
      end
      if (cmd.rem_load) begin
         r_ff    <= 9'(n_ff - dby);
         k_ff    <= '0;
         leap_ff <= leap;
      end else if (cmd.walk_step) begin
         r_ff <= r_ff - 9'(month_len(k_ff, leap_ff));
         k_ff <= k_ff + 4'd1;
      end
      if (cmd.fin) begin
         res_day_ff     <= rd_fin;
         res_month_ff   <= rm_fin;
         res_year_ff    <= ry_fin[YEAR_W-1:0];
         first_valid_ff <= valid_ff;
         compare_ff     <= cmp;
         distance_ff    <= dist_fin;
         error_ff       <= err_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.fin) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, error_ff, distance_ff, compare_ff, first_valid_ff,
                        res_year_ff, res_month_ff, res_day_ff};

   always_comb begin
      sts.op        = op_ff;
      sts.amt_neg   = amt_ff[AMT_W-1];
      sts.amt_zero  = (amt_ff == '0);
      sts.n_below   = (n_ff < DN_W'(DBY_BIAS));
      sts.dby_gt    = (dby > n_ff);
      sts.walk_more = (k_ff < 4'd11) && (r_ff >= 9'(month_len(k_ff, leap_ff)));
      sts.out_free  = !rsp_tvalid_ff || rsp_tready;
   end

`ifndef SYNTHESIS
   a_fin_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_tvalid_ff)
      else $error("result not presented after finish");
   a_err_nodist: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && error_ff) |-> (distance_ff == '0))
      else $error("error result carries a distance");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (k_ff < 4'd11))
      else $error("month walk past November");
`endif

endmodule

@@ hdl/gda_ctrl.sv @@
// Controller of the date arithmetic block: one-hot sequencer over validity check,
// day-count, year search, month walk and result hand-off. Depends on gda_pkg.
module gda_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output gda_pkg::cmd_type   cmd,
   input  gda_pkg::sts_type   sts
);
   import gda_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE  = 15'h0001,
      S_VWAIT = 15'h0002,
      S_VCAP  = 15'h0004,
      S_MQ    = 15'h0008,
      S_AWAIT = 15'h0010,
      S_ADN   = 15'h0020,
      S_BWAIT = 15'h0040,
      S_BDN   = 15'h0080,
      S_DCHK  = 15'h0100,
      S_SRCH  = 15'h0200,
      S_SWAIT = 15'h0400,
      S_FWAIT = 15'h0800,
      S_FREM  = 15'h1000,
      S_WALK  = 15'h2000,
      S_FIN   = 15'h4000
   } state_type;

   state_type state_ff, state_in;
   logic      dir_ff, dir_in;
   src_type   src_ff, src_in;

   always_comb begin
      state_in   = state_ff;
      dir_in     = dir_ff;
      src_in     = src_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.ysel   = YSEL_HOLD;
      cmd.src    = src_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               dir_in   = 1'b0;
               state_in = S_VWAIT;
            end
         end
         S_VWAIT: state_in = S_VCAP;
         S_VCAP: begin
            cmd.set_valid = 1'b1;
            if (sts.op == OP_DIST) begin
               cmd.ysel = YSEL_YY_A;
               state_in = S_AWAIT;
            end else if (sts.op == OP_RSVD) begin
               src_in   = SRC_NONE;
               state_in = S_FIN;
            end else if (sts.amt_neg) begin
               src_in   = SRC_ERR;
               state_in = S_FIN;
            end else if (sts.amt_zero) begin
               src_in   = SRC_A;
               state_in = S_FIN;
            end else begin
               case (sts.op) inside
                  OP_ADD_DAYS, OP_SUB_DAYS: begin
                     cmd.ysel = YSEL_YY_A;
                     state_in = S_AWAIT;
                  end
                  OP_ADD_MONTHS, OP_SUB_MONTHS: begin
                     cmd.t_load = 1'b1;
                     state_in   = S_MQ;
                  end
                  default: begin
                     src_in   = SRC_YEAR;
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_MQ: begin
            src_in   = SRC_MONTH;
            state_in = S_FIN;
         end
         S_AWAIT: state_in = S_ADN;
         S_ADN: begin
            cmd.n_load = 1'b1;
            if (sts.op == OP_DIST) begin
               cmd.ysel = YSEL_YY_B;
               state_in = S_BWAIT;
            end else begin
               state_in = S_DCHK;
            end
         end
         S_BWAIT: state_in = S_BDN;
         S_BDN: begin
            cmd.dist_load = 1'b1;
            src_in        = SRC_DIST;
            state_in      = S_FIN;
         end
         S_DCHK: begin
            if (sts.n_below) begin
               src_in   = SRC_ERR;
               state_in = S_FIN;
            end else begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.dby_gt) begin
               cmd.ysel = YSEL_DEC;
               state_in = dir_ff ? S_FWAIT : S_SWAIT;
            end else begin
               cmd.ysel = YSEL_INC;
               dir_in   = 1'b1;
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: state_in = S_SRCH;
         S_FWAIT: state_in = S_FREM;
         S_FREM: begin
            cmd.rem_load = 1'b1;
            state_in     = S_WALK;
         end
         S_WALK: begin
            if (sts.walk_more) begin
               cmd.walk_step = 1'b1;
            end else begin
               src_in   = SRC_DAY;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dir_ff   <= 1'b0;
         src_ff   <= SRC_NONE;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
         src_ff   <= src_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_VWAIT))
      else $error("item taken without starting the check");
   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> !sts.n_below)
      else $error("year search on a day number below year 0");
   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WALK) && !sts.walk_more) |=> (state_ff == S_FIN))
      else $error("month walk did not hand off the result");
`endif

endmodule

@@ hdl/gregorian_date_arithmetic.sv @@
// Top level of the Gregorian date arithmetic block: joins controller and datapath.
// Depends on gda_pkg, gda_ctrl, gda_dp.
//
//   channel   dir   fields (tdata / tuser)
//   req_      in    op; day_a month_a year_a amount day_b month_b year_b
//   rsp_      out   res_day res_month res_year first_valid compare distance error
//
// One item at a time. Year ops, zero or negative amounts and selector 7 skip to the
// result after the validity check; month ops add a month quotient; day distance
// converts both dates; day add/sub adds a year search, each step waiting for the
// day-count unit's registered quotients, and a month walk. Synchronous reset
// returns to idle with no result pending. A result waits in the output register
// while the next item is taken; a new result holds until that register is free.
module gregorian_date_arithmetic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // day_a[4:0] month_a[8:5] year_a[22:9] amount[38:23] day_b[43:39]
   // month_b[47:44] year_b[61:48], zero fill [63:62]
   input  logic [gda_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[2:0]
   input  logic [gda_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // res_day[4:0] res_month[8:5] res_year[22:9] first_valid[23] compare[25:24]
   // distance[47:26] error[48], zero fill [55:49]
   output logic [gda_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import gda_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   gda_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

@@ tb/gda_checker.sv @@
// Response checker for the Gregorian date arithmetic block: predicts each result from the
// accepted request item and compares it field by field with the returned item.
// Depends on gda_pkg.
module gda_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // day_a month_a year_a amount day_b month_b year_b, zero fill
   input  logic [gda_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [gda_pkg::OP_W-1:0]       req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // res_day res_month res_year first_valid compare distance error, zero fill
   input  logic [gda_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             failures,
   output int                             pending
);
   import gda_pkg::*;

   localparam longint DIST_SAT = 4194303;

   typedef struct packed {
      logic [1:0]         fill;
      logic [YEAR_W-1:0]  year_b;
      logic [MON_W-1:0]   month_b;
      logic [DAY_W-1:0]   day_b;
      logic [AMT_W-1:0]   amount;
      logic [YEAR_W-1:0]  year_a;
      logic [MON_W-1:0]   month_a;
      logic [DAY_W-1:0]   day_a;
   } date_request_type;

   typedef struct packed {
      logic               err;
      logic [DIST_W-1:0]  distance;
      logic [CMP_W-1:0]   cmp;
      logic               valid;
      logic [YEAR_W-1:0]  year;
      logic [MON_W-1:0]   month;
      logic [DAY_W-1:0]   day;
   } date_result_type;

   date_result_type due_results[$];
   int              mismatch_count = 0;
   int              due_count = 0;

   assign failures = mismatch_count;
   assign pending  = due_count;

   function automatic bit leap_year(longint y);
      if (y % 100 == 0) begin
         return (y % 400) == 0;
      end
      return (y % 4) == 0;
   endfunction

   function automatic longint month_days(longint k, bit leap);
      case (k)
         1:           return leap ? 29 : 28;
         3, 5, 8, 10: return 30;
         default:     return 31;
      endcase
   endfunction

   // days from the start of biased year 0 to the start of year y
   function automatic longint years_to_days(longint y);
      return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
   endfunction

   // months and days count linearly past the calendar bounds
   function automatic longint day_index(longint d, longint m, longint y);
      longint t, yy, mm, n;
      t  = (y + YEAR_BIAS) * 12 + m - 1;
      yy = t / 12;
      mm = t % 12;
      n  = years_to_days(yy) + d - 1;
      for (longint k = 0; k < mm; k++) begin
         n += month_days(k, leap_year(yy));
      end
      return n;
   endfunction

   function automatic date_result_type predict_date_op(op_type op, date_request_type q);
      date_result_type res;
      longint          amt, n, y, r, k, t, rd, rm, ry, diff;
      bit              below;
      res   = '0;
      below = 1'b0;
      rd    = 0;
      rm    = 0;
      ry    = 0;
      amt   = longint'($signed(q.amount));
      if (q.month_a >= 1 && q.month_a <= 12 && q.day_a >= 1) begin
         res.valid = q.day_a <= month_days(longint'(q.month_a) - 1,
                                           leap_year(longint'(q.year_a)));
      end
      if (q.year_a != q.year_b) begin
         res.cmp = q.year_a < q.year_b ? CMP_EARLIER : CMP_LATER;
      end else if (q.month_a != q.month_b) begin
         res.cmp = q.month_a < q.month_b ? CMP_EARLIER : CMP_LATER;
      end else if (q.day_a != q.day_b) begin
         res.cmp = q.day_a < q.day_b ? CMP_EARLIER : CMP_LATER;
      end else begin
         res.cmp = CMP_EQUAL;
      end
      case (op)
         OP_DIST: begin
            diff = day_index(longint'(q.day_a), longint'(q.month_a), longint'(q.year_a))
                   - day_index(longint'(q.day_b), longint'(q.month_b),
                               longint'(q.year_b));
            if (diff < 0) diff = -diff;
            if (diff > DIST_SAT) diff = DIST_SAT;
            res.distance = DIST_W'(diff);
            return res;
         end
         OP_RSVD: return res;
         default: ;
      endcase
      if (amt < 0) begin
         res.err = 1'b1;
         return res;
      end
      if (amt == 0) begin
         rd = longint'(q.day_a);
         rm = longint'(q.month_a);
         ry = longint'(q.year_a);
      end else begin
         case (op)
            OP_ADD_DAYS, OP_SUB_DAYS: begin
               n = day_index(longint'(q.day_a), longint'(q.month_a), longint'(q.year_a))
                   + (op == OP_ADD_DAYS ? amt : -amt);
               if (n < years_to_days(longint'(YEAR_BIAS))) begin
                  below = 1'b1;
               end else begin
                  y = n / 366;
                  while (years_to_days(y + 1) <= n) y++;
                  r = n - years_to_days(y);
                  k = 0;
                  while (k < 11 && r >= month_days(k, leap_year(y))) begin
                     r -= month_days(k, leap_year(y));
                     k++;
                  end
                  rd = r + 1;
                  rm = k + 1;
                  ry = y - YEAR_BIAS;
               end
            end
            OP_ADD_MONTHS, OP_SUB_MONTHS: begin
               t = longint'(q.year_a) * 12 + longint'(q.month_a) - 1
                   + (op == OP_ADD_MONTHS ? amt : -amt);
               if (t < 0) begin
                  below = 1'b1;
               end else begin
                  rd = longint'(q.day_a);
                  rm = t % 12 + 1;
                  ry = t / 12;
               end
            end
            default: begin
               rd = longint'(q.day_a);
               rm = longint'(q.month_a);
               ry = longint'(q.year_a) + (op == OP_ADD_YEARS ? amt : -amt);
               below = ry < 0;
            end
         endcase
      end
      if (below) begin
         res.err = 1'b1;
      end else if (ry > MAX_YEAR) begin
         res.day   = 5'd31;
         res.month = 4'd12;
         res.year  = YEAR_W'(MAX_YEAR);
         res.err   = 1'b1;
      end else begin
         res.day   = DAY_W'(rd);
         res.month = MON_W'(rm);
         res.year  = YEAR_W'(ry);
      end
      return res;
   endfunction

   task automatic check_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      date_request_type q;
      date_result_type  want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            q = req_tdata;
            due_results.push_back(predict_date_op(op_type'(req_tuser), q));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(date_result_type)-1:0];
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = due_results.pop_front();
               check_field("res_day", longint'(want.day), longint'(got.day));
               check_field("res_month", longint'(want.month), longint'(got.month));
               check_field("res_year", longint'(want.year), longint'(got.year));
               check_field("first_valid", longint'(want.valid), longint'(got.valid));
               check_field("compare", longint'(want.cmp), longint'(got.cmp));
               check_field("distance", longint'(want.distance), longint'(got.distance));
               check_field("error", longint'(want.err), longint'(got.err));
            end
         end
         due_count = due_results.size();
      end
   end

endmodule

@@ tb/tb_gregorian_date_arithmetic.sv @@
// Testbench top for gregorian_date_arithmetic: drives directed and random date requests
// with random gaps and stalls, and gives the verdict from gda_checker.
// Depends on gda_pkg, gregorian_date_arithmetic, gda_checker.
module tb_gregorian_date_arithmetic;
   import gda_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 250;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 560;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    failures;
   int                    pending;
   int                    cycle_count = 0;
   int                    sent = 0;
   bit                    steady_send = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   gregorian_date_arithmetic i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   gda_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic offer_item(op_type op, logic [DAY_W-1:0] da, logic [MON_W-1:0] ma,
                             logic [YEAR_W-1:0] ya, logic [AMT_W-1:0] amount,
                             logic [DAY_W-1:0] db, logic [MON_W-1:0] mb,
                             logic [YEAR_W-1:0] yb);
      int gap;
      gap = steady_send ? 0 : int'($urandom_range(0, 17));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, yb, mb, db, amount, ya, ma, da};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
      if (sent % 50 == 0) steady_send = $urandom_range(0, 2) == 0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic draw_date(output logic [DAY_W-1:0] d, output logic [MON_W-1:0] m,
                            output logic [YEAR_W-1:0] y);
      if ($urandom_range(0, 9) == 0) begin
         d = DAY_W'($urandom_range(0, 31));
         m = MON_W'($urandom_range(0, 15));
         y = YEAR_W'($urandom_range(0, 16383));
      end else begin
         case ($urandom_range(0, 3))
            0:       y = YEAR_W'($urandom_range(0, 20));
            1:       y = YEAR_W'($urandom_range(9980, 9999));
            default: y = YEAR_W'($urandom_range(0, 9999));
         endcase
         m = MON_W'($urandom_range(1, 12));
         if ($urandom_range(0, 4) == 0) begin
            d = DAY_W'($urandom_range(29, 31));
         end else begin
            d = DAY_W'($urandom_range(1, 28));
         end
      end
   endtask

   // result side: random stalls, one long hold-off to back up the block
   initial begin : result_sink
      int accepted;
      int gap;
      bit steady;
      accepted   = 0;
      steady     = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (accepted % 40 == 0) steady = $urandom_range(0, 2) == 0;
         gap = steady ? 0 : int'($urandom_range(0, 17));
         if (accepted == 120) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         accepted++;
         @(negedge clock);
      end
   end

   initial begin : request_source
      logic [DAY_W-1:0]  da, db;
      logic [MON_W-1:0]  ma, mb;
      logic [YEAR_W-1:0] ya, yb;
      logic [AMT_W-1:0]  amount;
      op_type            op;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ADD_DAYS;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_item(OP_ADD_DAYS, 5'd15, 4'd6, 14'd2020, 16'd0, 5'd15, 4'd6, 14'd2020);
      offer_item(OP_ADD_DAYS, 5'd1, 4'd1, 14'd2000, 16'hFFFF, 5'd2, 4'd1, 14'd2000);
      offer_item(OP_SUB_MONTHS, 5'd1, 4'd1, 14'd2000, 16'h8000, 5'd1, 4'd1, 14'd1999);
      offer_item(OP_ADD_DAYS, 5'd31, 4'd12, 14'd9999, 16'd1, 5'd31, 4'd12, 14'd9999);
      offer_item(OP_SUB_DAYS, 5'd1, 4'd1, 14'd0, 16'd1, 5'd0, 4'd0, 14'd0);
      offer_item(OP_ADD_DAYS, 5'd1, 4'd2, 14'd2000, 16'd60, 5'd1, 4'd3, 14'd2000);
      offer_item(OP_SUB_DAYS, 5'd1, 4'd3, 14'd1900, 16'd365, 5'd28, 4'd2, 14'd1900);
      offer_item(OP_ADD_DAYS, 5'd31, 4'd12, 14'd0, 16'd32767, 5'd31, 4'd12, 14'd0);
      offer_item(OP_ADD_DAYS, 5'd0, 4'd0, 14'd100, 16'd1, 5'd31, 4'd15, 14'd100);
      offer_item(OP_SUB_DAYS, 5'd31, 4'd15, 14'd16383, 16'd32767, 5'd0, 4'd0, 14'd16383);
      offer_item(OP_ADD_MONTHS, 5'd31, 4'd1, 14'd2023, 16'd1, 5'd28, 4'd2, 14'd2023);
      offer_item(OP_ADD_MONTHS, 5'd0, 4'd0, 14'd16383, 16'd0, 5'd0, 4'd0, 14'd0);
      offer_item(OP_SUB_MONTHS, 5'd0, 4'd0, 14'd0, 16'd1, 5'd0, 4'd0, 14'd0);
      offer_item(OP_SUB_MONTHS, 5'd15, 4'd13, 14'd5, 16'd13, 5'd15, 4'd13, 14'd5);
      offer_item(OP_ADD_MONTHS, 5'd10, 4'd12, 14'd9999, 16'd12, 5'd10, 4'd12, 14'd9998);
      offer_item(OP_ADD_YEARS, 5'd29, 4'd2, 14'd2000, 16'd1, 5'd29, 4'd2, 14'd2001);
      offer_item(OP_SUB_YEARS, 5'd1, 4'd1, 14'd2000, 16'd2000, 5'd1, 4'd1, 14'd2000);
      offer_item(OP_SUB_YEARS, 5'd1, 4'd1, 14'd2000, 16'd2001, 5'd1, 4'd1, 14'd2000);
      offer_item(OP_ADD_YEARS, 5'd1, 4'd1, 14'd1, 16'd32767, 5'd1, 4'd1, 14'd1);
      offer_item(OP_DIST, 5'd7, 4'd7, 14'd777, 16'h8000, 5'd7, 4'd7, 14'd777);
      offer_item(OP_DIST, 5'd0, 4'd0, 14'd0, 16'd0, 5'd31, 4'd15, 14'd16383);
      offer_item(OP_DIST, 5'd1, 4'd1, 14'd2024, 16'd5, 5'd1, 4'd1, 14'd2023);
      offer_item(OP_DIST, 5'd31, 4'd4, 14'd1900, 16'd0, 5'd29, 4'd2, 14'd1900);
      offer_item(OP_RSVD, 5'd30, 4'd2, 14'd2004, 16'hFFFF, 5'd31, 4'd12, 14'd2004);
      offer_item(OP_RSVD, 5'd29, 4'd2, 14'd1900, 16'd3, 5'd29, 4'd2, 14'd2000);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) drain_results();
         op = op_type'($urandom_range(0, 6));
         if ($urandom_range(0, 19) == 0) op = OP_RSVD;
         draw_date(da, ma, ya);
         case ($urandom_range(0, 3))
            0: begin
               db = da;
               mb = ma;
               yb = ya;
            end
            1: begin
               db = DAY_W'($urandom_range(0, 31));
               mb = ma;
               yb = ya;
            end
            default: draw_date(db, mb, yb);
         endcase
         case ($urandom_range(0, 9))
            0:       amount = AMT_W'($urandom_range(32768, 65535));
            1:       amount = 16'd0;
            2:       amount = AMT_W'($urandom_range(0, 32767));
            default: amount = AMT_W'($urandom_range(1, 400));
         endcase
         offer_item(op, da, ma, ya, amount, db, mb, yb);
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/gda_pkg.sv
hdl/gda_dp.sv
hdl/gda_ctrl.sv
hdl/gregorian_date_arithmetic.sv
tb/gda_checker.sv
tb/tb_gregorian_date_arithmetic.sv
